// ===== sv/crw_pkg.sv =====
// Shared types and constants for the compass routing weight block.
`default_nettype none
package crw_pkg;

    // Fixed width of the weight result field
    localparam int unsigned WEIGHT_W = 16;

    // Control bits that travel with each transaction down the pipeline
    typedef struct packed {
        logic vld;   // stage holds a transaction
        logic deg;   // a vector has zero length
        logic neg;   // dot product is positive, weight is negated
    } t_ctl;

endpackage
`default_nettype wire

// ===== sv/crw_if.sv =====
// Handshake channel interfaces for point-triple input and weight output.
`default_nettype none
interface crw_in_if #(
    parameter int unsigned COORD_BITS = 7
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;
    logic [COORD_BITS-1:0] nbr_x;
    logic [COORD_BITS-1:0] nbr_y;
    logic [COORD_BITS-1:0] dst_x;
    logic [COORD_BITS-1:0] dst_y;

    modport source (output valid, cur_x, cur_y, nbr_x, nbr_y, dst_x, dst_y, input ready);
    modport sink   (input valid, cur_x, cur_y, nbr_x, nbr_y, dst_x, dst_y, output ready);
endinterface

interface crw_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [crw_pkg::WEIGHT_W-1:0] angle_weight;
    logic                                degenerate;

    modport source (output valid, angle_weight, degenerate, input ready);
    modport sink   (input valid, angle_weight, degenerate, output ready);
endinterface
`default_nettype wire

// ===== sv/compass_routing_weight.sv =====
// Top level of the compass routing weight block.
// Computes the negated cosine of the angle between current->neighbor and
// current->destination as signed fixed point with FRAC_BITS fraction bits,
// truncated toward zero, exact to the last bit. A zero-length vector gives
// weight 0 with degenerate set. One transaction is accepted per cycle while no
// finished result is held. The pipeline has four front stages (differences, products,
// sums, length product), one cell per result bit deciding the magnitude by
// restoring square-root/divide steps, and the output register. The whole
// pipeline stalls only while a finished result waits to be taken.
`default_nettype none
module compass_routing_weight #(
    parameter int unsigned COORD_BITS = 7,
    parameter int unsigned FRAC_BITS  = 14
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    crw_in_if.sink    i_in,
    crw_out_if.source o_out
);

    localparam int unsigned MW = 4 * COORD_BITS + 4;
    localparam int unsigned SW = MW + 2 * FRAC_BITS;
    localparam int unsigned TW = MW + FRAC_BITS + 1;
    localparam int unsigned QW = FRAC_BITS + 1;
    localparam int unsigned NC = FRAC_BITS + 1;
    localparam int unsigned OW = (QW + 1 > crw_pkg::WEIGHT_W) ? QW + 1 : crw_pkg::WEIGHT_W;

    logic en;
    logic r_out_valid;
    logic signed [crw_pkg::WEIGHT_W-1:0] r_weight;
    logic r_deg;

    crw_pkg::t_ctl     c_ctl [NC+1];
    logic [MW-1:0]     c_m   [NC+1];
    logic [SW-1:0]     c_n2  [NC+1];
    logic [SW-1:0]     c_s   [NC+1];
    logic [TW-1:0]     c_t   [NC+1];
    logic [QW-1:0]     c_q   [NC+1];

    logic [OW-1:0]     n_mag;
    logic [OW-1:0]     n_wide;

    // whole pipeline advances unless a result is held
    assign en          = !r_out_valid || o_out.ready;
    assign i_in.ready  = en;

    crw_front #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (i_in.valid),
        .i_cur_x(i_in.cur_x),
        .i_cur_y(i_in.cur_y),
        .i_nbr_x(i_in.nbr_x),
        .i_nbr_y(i_in.nbr_y),
        .i_dst_x(i_in.dst_x),
        .i_dst_y(i_in.dst_y),
        .o_ctl  (c_ctl[0]),
        .o_m    (c_m[0]),
        .o_n2   (c_n2[0])
    );

    assign c_s[0] = '0;
    assign c_t[0] = '0;
    assign c_q[0] = '0;

    // chain of cells, most significant bit first
    for (genvar j = 0; j < NC; j++) begin : g_cell
        crw_cell #(
            .FRAC_BITS(FRAC_BITS),
            .MW       (MW),
            .BIT      (FRAC_BITS - j)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (c_ctl[j]),
            .i_m    (c_m[j]),
            .i_n2   (c_n2[j]),
            .i_s    (c_s[j]),
            .i_t    (c_t[j]),
            .i_q    (c_q[j]),
            .o_ctl  (c_ctl[j+1]),
            .o_m    (c_m[j+1]),
            .o_n2   (c_n2[j+1]),
            .o_s    (c_s[j+1]),
            .o_t    (c_t[j+1]),
            .o_q    (c_q[j+1])
        );
    end

    // sign and degenerate handling
    always_comb begin
        n_mag  = c_ctl[NC].deg ? '0 : OW'(c_q[NC]);
        n_wide = c_ctl[NC].neg ? OW'(-n_mag) : n_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_ctl[NC].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_weight <= signed'(n_wide[crw_pkg::WEIGHT_W-1:0]);
            r_deg    <= c_ctl[NC].deg;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.angle_weight = r_weight;
    assign o_out.degenerate   = r_deg;

    // degenerate transactions always carry a zero weight
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.degenerate) |-> (o_out.angle_weight == '0))
        else $error("degenerate result with nonzero weight");

    // a held result blocks new input
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while output stalled");

    // a held result stays in place
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.angle_weight)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

// ===== sv/crw_front.sv =====
// Front pipeline: difference vectors, dot product, squared lengths and their products.
`default_nettype none
module crw_front #(
    parameter int unsigned COORD_BITS = 7,
    parameter int unsigned FRAC_BITS  = 14,
    localparam int unsigned DW = COORD_BITS + 1,
    localparam int unsigned XW = 2 * COORD_BITS + 2,
    localparam int unsigned PW = 2 * COORD_BITS + 3,
    localparam int unsigned MW = 4 * COORD_BITS + 4,
    localparam int unsigned SW = MW + 2 * FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_vld,
    input  wire logic [COORD_BITS-1:0] i_cur_x,
    input  wire logic [COORD_BITS-1:0] i_cur_y,
    input  wire logic [COORD_BITS-1:0] i_nbr_x,
    input  wire logic [COORD_BITS-1:0] i_nbr_y,
    input  wire logic [COORD_BITS-1:0] i_dst_x,
    input  wire logic [COORD_BITS-1:0] i_dst_y,
    output crw_pkg::t_ctl              o_ctl,
    output logic [MW-1:0]              o_m,
    output logic [SW-1:0]              o_n2
);

    // stage 1: difference vectors
    logic               r_v1;
    logic signed [DW-1:0] r_vx, r_vy, r_dx, r_dy;
    // stage 2: products
    logic               r_v2;
    logic signed [XW-1:0] r_pxx, r_pyy, r_axx, r_ayy, r_bxx, r_byy;
    // stage 3: dot product and squared lengths
    crw_pkg::t_ctl      r_c3;
    logic [XW-1:0]      r_absp;
    logic [XW-1:0]      r_a, r_b;
    // stage 4: length product and squared dot product
    crw_pkg::t_ctl      r_c4;
    logic [MW-1:0]      r_m;
    logic [MW-1:0]      r_psq;

    logic signed [PW-1:0] n_p;
    logic [PW-1:0]        n_pa;
    logic [PW-1:0]        n_a, n_b;

    always_comb begin
        n_p  = PW'(r_pxx) + PW'(r_pyy);
        n_pa = n_p[PW-1] ? PW'(-n_p) : PW'(n_p);
        n_a  = PW'($unsigned(r_axx)) + PW'($unsigned(r_ayy));
        n_b  = PW'($unsigned(r_bxx)) + PW'($unsigned(r_byy));
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_c3.vld <= 1'b0;
            r_c4.vld <= 1'b0;
        end else if (i_en) begin
            r_v1     <= i_vld;
            r_v2     <= r_v1;
            r_c3.vld <= r_v2;
            r_c4.vld <= r_c3.vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vx  <= DW'(signed'({1'b0, i_nbr_x})) - DW'(signed'({1'b0, i_cur_x}));
            r_vy  <= DW'(signed'({1'b0, i_nbr_y})) - DW'(signed'({1'b0, i_cur_y}));
            r_dx  <= DW'(signed'({1'b0, i_dst_x})) - DW'(signed'({1'b0, i_cur_x}));
            r_dy  <= DW'(signed'({1'b0, i_dst_y})) - DW'(signed'({1'b0, i_cur_y}));
            r_pxx <= XW'(r_vx) * XW'(r_dx);
            r_pyy <= XW'(r_vy) * XW'(r_dy);
            r_axx <= XW'(r_vx) * XW'(r_vx);
            r_ayy <= XW'(r_vy) * XW'(r_vy);
            r_bxx <= XW'(r_dx) * XW'(r_dx);
            r_byy <= XW'(r_dy) * XW'(r_dy);
            r_c3.deg <= (n_a == '0) || (n_b == '0);
            r_c3.neg <= (n_p > 0);
            r_absp   <= n_pa[XW-1:0];
            r_a      <= n_a[XW-1:0];
            r_b      <= n_b[XW-1:0];
            r_c4.deg <= r_c3.deg;
            r_c4.neg <= r_c3.neg;
            r_m      <= MW'(r_a) * MW'(r_b);
            r_psq    <= MW'(r_absp) * MW'(r_absp);
        end
    end

    assign o_ctl = r_c4;
    assign o_m   = r_m;
    assign o_n2  = SW'(r_psq) << (2 * FRAC_BITS);

endmodule
`default_nettype wire

// ===== sv/crw_cell.sv =====
// One cell of the root/divide chain: decides one bit of the weight magnitude.
`default_nettype none
module crw_cell #(
    parameter int unsigned FRAC_BITS = 14,
    parameter int unsigned MW        = 32,
    parameter int unsigned BIT       = 0,
    localparam int unsigned SW = MW + 2 * FRAC_BITS,
    localparam int unsigned TW = MW + FRAC_BITS + 1,
    localparam int unsigned QW = FRAC_BITS + 1,
    localparam int unsigned ZW = SW + 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire crw_pkg::t_ctl i_ctl,
    input  wire logic [MW-1:0] i_m,
    input  wire logic [SW-1:0] i_n2,
    input  wire logic [SW-1:0] i_s,
    input  wire logic [TW-1:0] i_t,
    input  wire logic [QW-1:0] i_q,
    output crw_pkg::t_ctl      o_ctl,
    output logic [MW-1:0]      o_m,
    output logic [SW-1:0]      o_n2,
    output logic [SW-1:0]      o_s,
    output logic [TW-1:0]      o_t,
    output logic [QW-1:0]      o_q
);

    // S tracks q^2*M and T tracks q*M; setting bit k adds 2^(k+1)*T + 4^k*M
    logic [ZW-1:0] n_trial;
    logic          n_take;

    always_comb begin
        n_trial = ZW'(i_s) + (ZW'(i_t) << (BIT + 1)) + (ZW'(i_m) << (2 * BIT));
        n_take  = (n_trial <= ZW'(i_n2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else if (i_en) begin
            o_ctl.vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl.deg <= i_ctl.deg;
            o_ctl.neg <= i_ctl.neg;
            o_m       <= i_m;
            o_n2      <= i_n2;
            if (n_take) begin
                o_s <= n_trial[SW-1:0];
                o_t <= i_t + (TW'(i_m) << BIT);
                o_q <= i_q | (QW'(1) << BIT);
            end else begin
                o_s <= i_s;
                o_t <= i_t;
                o_q <= i_q;
            end
        end
    end

endmodule
`default_nettype wire

// ===== verif/compass_routing_weight_check.sv =====
// Checker for the compass routing weight block: predicts each weight and compares results.
module compass_routing_weight_check #(
    parameter int unsigned COORD_BITS = 7,
    parameter int unsigned FRAC_BITS  = 14
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    crw_in_if         i_in,
    crw_out_if        i_out,
    output int        o_fail_cnt,
    output int        o_pending
);

    typedef struct {
        logic signed [crw_pkg::WEIGHT_W-1:0] weight;
        logic                                deg;
    } t_weight;

    t_weight weight_q[$];

    // Exact negated cosine: largest q with q^2*A*B <= (|P|*2^F)^2
    function automatic t_weight calc_weight(
        input logic [COORD_BITS-1:0] cx, cy, vx, vy, dx, dy);
        longint ax, ay, bx, by, prod, a, b, lo, hi, mid, w;
        logic [255:0] m, nn, t, n;
        t_weight r;
        ax = longint'(vx) - longint'(cx);
        ay = longint'(vy) - longint'(cy);
        bx = longint'(dx) - longint'(cx);
        by = longint'(dy) - longint'(cy);
        prod = ax * bx + ay * by;
        a = ax * ax + ay * ay;
        b = bx * bx + by * by;
        if (a == 0 || b == 0) begin
            r.weight = '0;
            r.deg    = 1'b1;
            return r;
        end
        n  = 256'(prod < 0 ? -prod : prod) << FRAC_BITS;
        nn = n * n;
        m  = 256'(a) * 256'(b);
        lo = 0;
        hi = longint'(1) << FRAC_BITS;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 256'(mid) * 256'(mid) * m;
            if (t <= nn) lo = mid;
            else hi = mid - 1;
        end
        w = prod > 0 ? -lo : lo;
        r.weight = w[crw_pkg::WEIGHT_W-1:0];
        r.deg    = 1'b0;
        return r;
    endfunction

    // Predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_weight exp_w;
        if (!i_rst_n) begin
            o_fail_cnt <= 0;
        end else begin
            if (i_in.valid && i_in.ready)
                weight_q.push_back(calc_weight(i_in.cur_x, i_in.cur_y, i_in.nbr_x,
                                               i_in.nbr_y, i_in.dst_x, i_in.dst_y));
            if (i_out.valid && i_out.ready) begin
                if (weight_q.size() == 0) begin
                    $error("unexpected result: angle_weight %0d", i_out.angle_weight);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    exp_w = weight_q.pop_front();
                    if (i_out.angle_weight !== exp_w.weight || i_out.degenerate !== exp_w.deg)
                        o_fail_cnt <= o_fail_cnt + 1;
                    if (i_out.angle_weight !== exp_w.weight)
                        $error("angle_weight: expected %0d, actual %0d",
                               exp_w.weight, i_out.angle_weight);
                    if (i_out.degenerate !== exp_w.deg)
                        $error("degenerate: expected %0d, actual %0d",
                               exp_w.deg, i_out.degenerate);
                end
            end
        end
        // transactions still waiting for their result
        o_pending <= weight_q.size();
    end
endmodule

// ===== verif/compass_routing_weight_test.sv =====
// Testbench top for the compass routing weight block: stimulus, reset and verdict.
module compass_routing_weight_test;
    localparam int unsigned COORD_BITS = 7;
    localparam int unsigned FRAC_BITS  = 14;
    localparam int          NUM_RAND   = 900;
    localparam int          WDOG_LIMIT = 2000;
    localparam int          LATENCY    = FRAC_BITS + 6;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   pending;
    int   idle_cnt;
    int   cyc;
    bit   busy_phase;

    crw_in_if #(.COORD_BITS(COORD_BITS)) in_ch();
    crw_out_if out_ch();

    compass_routing_weight #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    compass_routing_weight_check #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stall window on the output side, with a long no-stall stretch
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= busy_phase ? 1'b1 : ($urandom_range(99) >= 38);
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cnt <= 0;
        else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Send one point triple, with a random idle gap first
    task automatic send_pts(input logic [6:0] cx, cy, vx, vy, dx, dy);
        while (!busy_phase && $urandom_range(99) < 38) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cur_x <= cx; in_ch.cur_y <= cy;
        in_ch.nbr_x <= vx; in_ch.nbr_y <= vy;
        in_ch.dst_x <= dx; in_ch.dst_y <= dy;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [6:0] rnd_c();
        return 7'($urandom_range(127));
    endfunction

    initial begin
        logic [6:0] cx, cy;
        int k;
        cyc = 0;
        busy_phase = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cur_x = '0; in_ch.cur_y = '0; in_ch.nbr_x = '0;
        in_ch.nbr_y = '0; in_ch.dst_x = '0; in_ch.dst_y = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero-length vectors, extremes, parallel, opposite, orthogonal
        send_pts(10, 10, 10, 10, 50, 60);
        send_pts(10, 10, 40, 3, 10, 10);
        send_pts(0, 0, 0, 0, 0, 0);
        send_pts(127, 127, 127, 127, 127, 127);
        send_pts(0, 0, 127, 127, 127, 127);
        send_pts(0, 0, 127, 127, 1, 1);
        send_pts(127, 127, 0, 0, 127, 0);
        send_pts(0, 0, 127, 0, 0, 127);
        send_pts(64, 64, 127, 64, 0, 64);
        send_pts(64, 64, 0, 0, 127, 127);
        send_pts(0, 127, 127, 0, 1, 126);
        send_pts(0, 0, 127, 1, 126, 1);
        send_pts(127, 0, 0, 127, 0, 126);
        send_pts(5, 9, 6, 9, 5, 10);
        send_pts(1, 2, 4, 6, 4, 6);
        send_pts(50, 50, 53, 54, 47, 46);
        send_pts(0, 0, 3, 4, 4, 3);

        // Random: mostly general triples, some small offsets and coincident points
        for (k = 0; k < NUM_RAND; k++) begin
            busy_phase = (k >= 400 && k < 500);
            cx = rnd_c(); cy = rnd_c();
            case ($urandom_range(9))
                0: send_pts(cx, cy, cx, cy, rnd_c(), rnd_c());
                1: send_pts(cx, cy, rnd_c(), rnd_c(), cx, cy);
                2, 3: send_pts(cx, cy, cx + 7'($urandom_range(4)) - 7'd2,
                               cy + 7'($urandom_range(4)) - 7'd2,
                               cx + 7'($urandom_range(4)) - 7'd2,
                               cy + 7'($urandom_range(4)) - 7'd2);
                default: send_pts(cx, cy, rnd_c(), rnd_c(), rnd_c(), rnd_c());
            endcase
        end
        busy_phase = 1'b0;
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
